>>> design/tps_pkg.sv
// tps_pkg: shared types and constants for the text paragraph segmenter.
// Holds the command and result structs, sequencer state codes and byte codes.
// No dependencies.
`timescale 1ns / 1ps

package tps_pkg;

    localparam int TPS_HOLD_DEPTH = 32;     // default hold buffer depth
    localparam int TPS_CNT_W      = 6;      // holds any held count for depth up to 63
    localparam int TPS_QDEPTH     = 4;      // command queue depth
    localparam int TPS_QPTR_W     = 2;
    localparam int TPS_PEND_W     = 3;      // outstanding flushes: queue plus one in service

    localparam logic [4:0] TPS_MIN_LEN_RESET = 5'd10;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam logic [1:0] NL_NONE = 2'd0;
    localparam logic [1:0] NL_ONE  = 2'd1;

    // One request's worth of work for the back end
    typedef struct packed {
        logic [TPS_CNT_W-1:0] flush_n;      // held bytes to replay first
        logic                 emit_byte;    // then the text byte itself
        logic [7:0]           text_byte;
        logic                 seg_mark;     // segment close on blank line
        logic                 done_mark;    // end of text marker
        logic                 done_seg_end;
        logic                 done_status;
        logic                 ovf_main;     // overflow flag for bytes and segment marker
        logic                 ovf_done;     // overflow flag for the end of text marker
    } tps_cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       segment_end;
        logic       text_done;
        logic       status;
        logic       overflow;
        logic       last_of_run;
    } tps_res_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FLUSH = 5'b00010,
        ST_BYTE  = 5'b00100,
        ST_SEG   = 5'b01000,
        ST_DONE  = 5'b10000
    } tps_state_t;

endpackage

>>> design/tps_ram.sv
// tps_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/tps_cmd_fifo.sv
// tps_cmd_fifo: short command queue between the front and back ends.
// Depends on tps_pkg.
`timescale 1ns / 1ps

module tps_cmd_fifo
    import tps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  tps_cmd_t push_cmd,
    input  logic     pop,
    output tps_cmd_t head,
    output logic     not_empty,
    output logic     full
);

    tps_cmd_t              entry_reg [TPS_QDEPTH];
    logic [TPS_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [TPS_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [TPS_QPTR_W:0]   cnt_reg, cnt_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == (TPS_QPTR_W+1)'(TPS_QDEPTH));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {{TPS_QPTR_W{1'b0}}, push} - {{TPS_QPTR_W{1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> design/tps_front.sv
// tps_front: accepts input bytes, normalises and classifies them, keeps the
// segment state, writes held bytes into the hold RAM and queues commands.
// Depends on tps_pkg.
`timescale 1ns / 1ps

module tps_front
    import tps_pkg::*;
#(
    parameter int HOLD_DEPTH = TPS_HOLD_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_text_byte,
    input  logic                          s_has_byte,
    input  logic                          s_end_of_text,
    input  logic [4:0]                    min_len,
    output logic                          ram_we,
    output logic [$clog2(HOLD_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                    ram_wdata,
    output logic                          cmd_push,
    output tps_cmd_t                      cmd,
    input  logic                          cmd_full,
    input  logic                          flush_done
);

    localparam int AW = $clog2(HOLD_DEPTH);
    localparam int CW = AW + 1;

    logic                  acr_reg, acr_next;
    logic [1:0]            nl_reg, nl_next;
    logic                  started_reg, started_next;
    logic                  emit_reg, emit_next;
    logic [AW-1:0]         hc_reg, hc_next;
    logic                  seen_reg, seen_next;
    logic                  ovf_reg, ovf_next;
    logic [TPS_PEND_W-1:0] pend_reg, pend_next;

    logic          accept;
    logic          keep;
    logic [7:0]    c;
    logic          do_space, do_text, do_seg;
    logic [CW-1:0] hc_inc;
    logic          space_fits, reach_min;
    logic          needs_write;
    logic          flush_busy;

    assign hc_inc     = {1'b0, hc_reg} + CW'(1);
    assign space_fits = hc_inc < CW'(HOLD_DEPTH);
    // A min of 0 acts as 1 and one above the depth as the depth: both fall out here
    assign reach_min  = (hc_inc >= CW'(min_len)) || !space_fits;
    assign flush_busy = (pend_reg != '0);

    always_comb begin
        c    = (s_text_byte == CH_CR) ? CH_LF : s_text_byte;
        keep = s_has_byte && !(acr_reg && s_text_byte == CH_LF) &&
               !((c < CH_SP && c != CH_LF && c != CH_TAB) || c == CH_DEL);
        do_space = keep && ((c == CH_LF && nl_reg == NL_NONE) || c == CH_SP || c == CH_TAB);
        do_seg   = keep && c == CH_LF && nl_reg == NL_ONE;
        do_text  = keep && c != CH_LF && c != CH_SP && c != CH_TAB;
        needs_write = (do_space && started_reg && space_fits) ||
                      (do_text && !emit_reg && !reach_min);
    end

    assign s_ready   = !cmd_full && !(needs_write && flush_busy);
    assign accept    = s_valid && s_ready;
    assign ram_we    = accept && needs_write;
    assign ram_waddr = hc_reg;
    assign ram_wdata = c;

    always_comb begin
        acr_next     = acr_reg;
        nl_next      = nl_reg;
        started_next = started_reg;
        emit_next    = emit_reg;
        hc_next      = hc_reg;
        seen_next    = seen_reg;
        ovf_next     = ovf_reg;
        cmd          = '0;
        cmd.text_byte = c;
        cmd.ovf_main  = ovf_reg;

        if (s_has_byte) begin
            seen_next = 1'b1;
            acr_next  = (s_text_byte == CH_CR);
        end
        if (keep) begin
            if (c == CH_LF) begin
                if (nl_reg == NL_NONE) begin
                    nl_next = NL_ONE;
                end else begin
                    nl_next = 2'd2;
                end
            end else begin
                nl_next = NL_NONE;
            end
        end
        if (do_space && started_reg) begin
            if (space_fits) begin
                hc_next = hc_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (do_text) begin
            started_next = 1'b1;
            if (emit_reg || reach_min) begin
                emit_next     = 1'b1;
                cmd.flush_n   = TPS_CNT_W'(hc_reg);
                cmd.emit_byte = 1'b1;
                hc_next       = '0;
            end else begin
                hc_next = hc_reg + 1'b1;
            end
        end
        if (do_seg) begin
            cmd.seg_mark = emit_reg;
            started_next = 1'b0;
            emit_next    = 1'b0;
            hc_next      = '0;
            ovf_next     = 1'b0;
        end
        if (s_end_of_text) begin
            cmd.done_mark    = 1'b1;
            cmd.done_seg_end = emit_next;
            cmd.done_status  = !seen_next;
            cmd.ovf_done     = ovf_next;
            started_next     = 1'b0;
            emit_next        = 1'b0;
            hc_next          = '0;
            ovf_next         = 1'b0;
            acr_next         = 1'b0;
            nl_next          = NL_NONE;
            seen_next        = 1'b0;
        end
    end

    assign cmd_push = accept && (cmd.emit_byte || cmd.seg_mark || cmd.done_mark);

    always_comb begin
        pend_next = pend_reg
                  + {{(TPS_PEND_W-1){1'b0}}, cmd_push && cmd.flush_n != '0}
                  - {{(TPS_PEND_W-1){1'b0}}, flush_done};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acr_reg     <= 1'b0;
            nl_reg      <= NL_NONE;
            started_reg <= 1'b0;
            emit_reg    <= 1'b0;
            hc_reg      <= '0;
            seen_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            pend_reg    <= '0;
        end else begin
            if (accept) begin
                acr_reg     <= acr_next;
                nl_reg      <= nl_next;
                started_reg <= started_next;
                emit_reg    <= emit_next;
                hc_reg      <= hc_next;
                seen_reg    <= seen_next;
                ovf_reg     <= ovf_next;
            end
            pend_reg <= pend_next;
        end
    end

endmodule

>>> design/tps_back.sv
// tps_back: pops commands, replays held bytes from the hold RAM, emits text
// bytes and markers, and buffers results in a two entry output queue.
// Depends on tps_pkg.
`timescale 1ns / 1ps

module tps_back
    import tps_pkg::*;
#(
    parameter int HOLD_DEPTH = TPS_HOLD_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  tps_cmd_t                      cmd_head,
    output logic                          cmd_pop,
    output logic                          ram_re,
    output logic [$clog2(HOLD_DEPTH)-1:0] ram_raddr,
    input  logic [7:0]                    ram_rdata,
    output logic                          flush_done,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tps_res_t                      m_res
);

    localparam int AW = $clog2(HOLD_DEPTH);
    localparam int CW = AW + 1;

    tps_state_t st_reg, st_next;
    tps_cmd_t   cur_reg, cur_next;
    logic [AW-1:0] idx_reg, idx_next;

    logic     stage_valid_reg;
    logic     stage_ram_reg;
    tps_res_t stage_res_reg, stage_res_next;

    tps_res_t   oq_reg [2];
    logic       oq_wr_reg, oq_rd_reg;
    logic [1:0] oq_cnt_reg;

    logic       oq_pop, oq_push, room, issue, flush_last, is_last;
    logic [2:0] occ_after;
    tps_state_t follow;
    tps_res_t   push_res;

    function automatic tps_state_t pick(input logic b, input logic s, input logic d);
        tps_state_t r;
        if (b) begin
            r = ST_BYTE;
        end else if (s) begin
            r = ST_SEG;
        end else if (d) begin
            r = ST_DONE;
        end else begin
            r = ST_IDLE;
        end
        return r;
    endfunction

    function automatic tps_state_t first_of(input tps_cmd_t k);
        tps_state_t r;
        if (k.flush_n != '0) begin
            r = ST_FLUSH;
        end else begin
            r = pick(k.emit_byte, k.seg_mark, k.done_mark);
        end
        return r;
    endfunction

    // Output queue credit counts the result in flight through the RAM stage
    assign oq_pop    = (oq_cnt_reg != 2'd0) && m_ready;
    assign occ_after = {1'b0, oq_cnt_reg} + {2'b0, stage_valid_reg} - {2'b0, oq_pop};
    assign room      = occ_after < 3'd2;
    assign issue     = (st_reg != ST_IDLE) && room;
    assign flush_last = ({1'b0, idx_reg} + CW'(1)) == CW'(cur_reg.flush_n);

    always_comb begin
        case (st_reg)
            ST_FLUSH: follow = flush_last ?
                               pick(cur_reg.emit_byte, cur_reg.seg_mark, cur_reg.done_mark) :
                               ST_FLUSH;
            ST_BYTE:  follow = pick(1'b0, cur_reg.seg_mark, cur_reg.done_mark);
            ST_SEG:   follow = pick(1'b0, 1'b0, cur_reg.done_mark);
            default:  follow = ST_IDLE;
        endcase
    end
    assign is_last = (follow == ST_IDLE);

    always_comb begin
        st_next  = st_reg;
        cur_next = cur_reg;
        idx_next = idx_reg;
        cmd_pop  = 1'b0;
        if (st_reg == ST_IDLE) begin
            if (cmd_valid) begin
                cmd_pop  = 1'b1;
                cur_next = cmd_head;
                idx_next = '0;
                st_next  = first_of(cmd_head);
            end
        end else if (issue) begin
            if (is_last) begin
                if (cmd_valid) begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd_head;
                    idx_next = '0;
                    st_next  = first_of(cmd_head);
                end else begin
                    st_next = ST_IDLE;
                end
            end else begin
                st_next = follow;
                if (st_reg == ST_FLUSH) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    assign ram_re     = issue && (st_reg == ST_FLUSH);
    assign ram_raddr  = idx_reg;
    assign flush_done = ram_re && flush_last;

    always_comb begin
        stage_res_next             = '0;
        stage_res_next.out_byte    = (st_reg == ST_BYTE) ? cur_reg.text_byte : 8'd0;
        stage_res_next.byte_valid  = (st_reg == ST_FLUSH) || (st_reg == ST_BYTE);
        stage_res_next.segment_end = (st_reg == ST_SEG) ||
                                     ((st_reg == ST_DONE) && cur_reg.done_seg_end);
        stage_res_next.text_done   = (st_reg == ST_DONE);
        stage_res_next.status      = (st_reg == ST_DONE) && cur_reg.done_status;
        stage_res_next.overflow    = (st_reg == ST_DONE) ? cur_reg.ovf_done : cur_reg.ovf_main;
        stage_res_next.last_of_run = is_last;
    end

    always_comb begin
        push_res = stage_res_reg;
        if (stage_ram_reg) begin
            push_res.out_byte = ram_rdata;
        end
    end
    assign oq_push = stage_valid_reg;

    assign m_valid = (oq_cnt_reg != 2'd0);
    assign m_res   = oq_reg[oq_rd_reg];

    always_ff @(posedge aclk) begin
        if (issue) begin
            stage_res_reg <= stage_res_next;
            stage_ram_reg <= (st_reg == ST_FLUSH);
        end
        if (st_reg == ST_IDLE || (issue && is_last) || issue) begin
            cur_reg <= cur_next;
        end
        if (oq_push) begin
            oq_reg[oq_wr_reg] <= push_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg          <= ST_IDLE;
            idx_reg         <= '0;
            stage_valid_reg <= 1'b0;
            oq_wr_reg       <= 1'b0;
            oq_rd_reg       <= 1'b0;
            oq_cnt_reg      <= 2'd0;
        end else begin
            st_reg          <= st_next;
            idx_reg         <= idx_next;
            stage_valid_reg <= issue;
            oq_wr_reg       <= oq_wr_reg ^ oq_push;
            oq_rd_reg       <= oq_rd_reg ^ oq_pop;
            oq_cnt_reg      <= oq_cnt_reg + {1'b0, oq_push} - {1'b0, oq_pop};
        end
    end

endmodule

>>> design/text_paragraph_segmenter_top.sv
// text_paragraph_segmenter_top: top level of the paragraph segmenter.
// Instantiates tps_front, tps_cmd_fifo, tps_back and tps_ram; uses tps_pkg.
// Holds the minimum segment length register.
//
//  Channel | Direction | Handshake            | Carries
//  --------+-----------+----------------------+------------------------------------
//  s_      | in        | s_valid / s_ready    | text_byte, has_byte, end_of_text
//  m_      | out       | m_valid / m_ready    | out_byte, byte_valid, segment_end,
//          |           |                      | text_done, status, overflow, last_of_run
//  cfg_    | in        | cfg_valid / cfg_ready| min_segment_length (5 bits)
//
// Flow: the front takes one request per cycle while s_ready is high. The back sends
// one result per cycle while its output queue has room; a request that replays n
// held bytes sends them before its own text byte and markers.
// A request that must write the hold RAM waits while a replay of that RAM is
// still queued or under way (the single RAM is shared by both ends).
// Reset: synchronous, active low; no clearing pass, the hold RAM is never read
// before it is written.
// Stalls: the four entry command queue and the two entry output queue let the
// front keep accepting while m_ready is low, until the command queue fills.
`timescale 1ns / 1ps

module text_paragraph_segmenter_top
    import tps_pkg::*;
#(
    parameter int HOLD_DEPTH = TPS_HOLD_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_has_byte,
    input  logic       s_end_of_text,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_segment_end,
    output logic       m_text_done,
    output logic       m_status,
    output logic       m_overflow,
    output logic       m_last_of_run,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_min_segment_length
);

    localparam int AW = $clog2(HOLD_DEPTH);

    // Minimum trimmed length; write only while the block is quiet (the block does not enforce this)
    logic [4:0] min_len_reg;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic     cmd_push, cmd_pop, cmd_full, cmd_valid;
    tps_cmd_t cmd_in, cmd_head;
    logic     flush_done;
    tps_res_t m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= TPS_MIN_LEN_RESET;
        end else if (cfg_valid) begin
            min_len_reg <= cfg_min_segment_length;
        end
    end

    // Front: normalisation, filtering, trimming decisions, hold RAM writes
    tps_front #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_has_byte    (s_has_byte),
        .s_end_of_text (s_end_of_text),
        .min_len       (min_len_reg),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in),
        .cmd_full      (cmd_full),
        .flush_done    (flush_done)
    );

    // Commands between the two ends
    tps_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_cmd  (cmd_in),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .not_empty (cmd_valid),
        .full      (cmd_full)
    );

    // Hold buffer: bytes that may still be trimmed or wait for the minimum
    tps_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Back: replays held bytes, emits bytes and markers
    tps_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (cmd_valid),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .flush_done (flush_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_out_byte    = m_res.out_byte;
    assign m_byte_valid  = m_res.byte_valid;
    assign m_segment_end = m_res.segment_end;
    assign m_text_done   = m_res.text_done;
    assign m_status      = m_res.status;
    assign m_overflow    = m_res.overflow;
    assign m_last_of_run = m_res.last_of_run;

endmodule

>>> bench/testbench.sv
// testbench: self-checking bench for text_paragraph_segmenter_top.
// Queue-fed request driver, clocked result monitor and an in-bench predictor.
// Depends on tps_pkg and the segmenter RTL only.
`timescale 1ns / 1ps

module testbench;
    import tps_pkg::*;

    localparam logic [1:0] NL_MANY    = 2'd2;   // blank line already seen
    localparam logic       STAT_OK    = 1'b0;
    localparam logic       STAT_EMPTY = 1'b1;   // text closed with no byte in it
    localparam int         HOLD_AW    = $clog2(TPS_HOLD_DEPTH);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       end_of_text;
    } text_req_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'h00;
    logic       s_has_byte = 1'b0;
    logic       s_end_of_text = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_segment_end;
    logic       m_text_done;
    logic       m_status;
    logic       m_overflow;
    logic       m_last_of_run;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_min_segment_length = TPS_MIN_LEN_RESET;

    text_req_t   text_requests [$];        // requests not yet offered
    tps_res_t    segment_results_due [$];  // predicted results, oldest first
    text_req_t   next_req;
    int unsigned queued_count = 0;         // requests that do something
    int unsigned request_cap = 32'hFFFF_FFFF; // no more requests queued past this count
    int unsigned send_gap_pct = 14;
    int unsigned recv_stall_pct = 50;
    int unsigned mismatch_count = 0;

    // Predictor state
    logic       cr_pending;
    logic [1:0] lf_run;
    logic       seg_open;
    logic       seg_live;
    logic [5:0] hold_cnt;
    logic [7:0] hold_mem [0:TPS_HOLD_DEPTH-1];
    logic       text_seen;
    logic       ovf_flag;
    logic [4:0] min_len;

    // Last result of a request is held back so last_of_run can be set on it
    tps_res_t   run_tail;
    logic       run_has_tail;

    text_paragraph_segmenter_top dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_text_byte            (s_text_byte),
        .s_has_byte             (s_has_byte),
        .s_end_of_text          (s_end_of_text),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_out_byte             (m_out_byte),
        .m_byte_valid           (m_byte_valid),
        .m_segment_end          (m_segment_end),
        .m_text_done            (m_text_done),
        .m_status               (m_status),
        .m_overflow             (m_overflow),
        .m_last_of_run          (m_last_of_run),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_min_segment_length (cfg_min_segment_length)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic add_result(input logic [7:0] b, input logic valid, input logic seg_end,
                              input logic done, input logic stat);
        tps_res_t r;
        r.out_byte    = b;
        r.byte_valid  = valid;
        r.segment_end = seg_end;
        r.text_done   = done;
        r.status      = stat;
        r.overflow    = ovf_flag;
        r.last_of_run = 1'b0;
        if (run_has_tail)
            segment_results_due.insert(segment_results_due.size(), run_tail);
        run_tail     = r;
        run_has_tail = 1'b1;
    endtask

    task automatic close_segment();
        seg_open = 1'b0;
        seg_live = 1'b0;
        hold_cnt = '0;
        ovf_flag = 1'b0;
    endtask

    // Whitespace is only worth holding once the segment has real text in it
    task automatic take_blank(input logic [7:0] c);
        if (seg_open) begin
            if (hold_cnt + 1 < TPS_HOLD_DEPTH) begin
                hold_mem[hold_cnt[HOLD_AW-1:0]] = c;
                hold_cnt = hold_cnt + 1'b1;
            end else begin
                ovf_flag = 1'b1;
            end
        end
    endtask

    task automatic take_text(input logic [7:0] c);
        int unsigned need;
        int i;
        need = (min_len == 0) ? 1 : min_len;
        if (need > TPS_HOLD_DEPTH)
            need = TPS_HOLD_DEPTH;
        seg_open = 1'b1;
        // emitting already, long enough now, or hold buffer about to fill
        if (seg_live || hold_cnt + 1 >= need || hold_cnt + 1 >= TPS_HOLD_DEPTH) begin
            seg_live = 1'b1;
            for (i = 0; i < hold_cnt; i++)
                add_result(hold_mem[i[HOLD_AW-1:0]], 1'b1, 1'b0, 1'b0, STAT_OK);
            add_result(c, 1'b1, 1'b0, 1'b0, STAT_OK);
            hold_cnt = '0;
        end else begin
            hold_mem[hold_cnt[HOLD_AW-1:0]] = c;
            hold_cnt = hold_cnt + 1'b1;
        end
    endtask

    task automatic predict_segments(input logic [7:0] raw, input logic has,
                                    input logic closes);
        logic       keep;
        logic [7:0] c;
        run_has_tail = 1'b0;
        if (has) begin
            keep = 1'b1;
            c = raw;
            text_seen = 1'b1;
            // CR LF folds to one LF, a lone CR becomes LF
            if (cr_pending && raw == CH_LF) begin
                keep = 1'b0;
                cr_pending = 1'b0;
            end else if (raw == CH_CR) begin
                c = CH_LF;
                cr_pending = 1'b1;
            end else begin
                cr_pending = 1'b0;
            end
            if (keep && ((c < CH_SP && c != CH_LF && c != CH_TAB) || c == CH_DEL))
                keep = 1'b0;
            if (keep) begin
                if (c == CH_LF) begin
                    if (lf_run == NL_NONE) begin
                        lf_run = NL_ONE;
                        take_blank(c);
                    end else if (lf_run == NL_ONE) begin
                        lf_run = NL_MANY;
                        if (seg_live)
                            add_result(8'h00, 1'b0, 1'b1, 1'b0, STAT_OK);
                        close_segment();
                    end
                end else begin
                    lf_run = NL_NONE;
                    if (c == CH_SP || c == CH_TAB)
                        take_blank(c);
                    else
                        take_text(c);
                end
            end
        end
        if (closes) begin
            add_result(8'h00, 1'b0, seg_live, 1'b1, text_seen ? STAT_OK : STAT_EMPTY);
            close_segment();
            cr_pending = 1'b0;
            lf_run = NL_NONE;
            text_seen = 1'b0;
        end
        if (run_has_tail) begin
            run_tail.last_of_run = 1'b1;
            segment_results_due.insert(segment_results_due.size(), run_tail);
            run_has_tail = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: predicts on acceptance, then offers the next request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_segments(s_text_byte, s_has_byte, s_end_of_text);
            if (!s_valid || s_ready) begin
                if (text_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_req = text_requests.pop_front();
                    s_valid       <= 1'b1;
                    s_text_byte   <= next_req.text_byte;
                    s_has_byte    <= next_req.has_byte;
                    s_end_of_text <= next_req.end_of_text;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (segment_results_due.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got byte %0h",
                             $time, m_out_byte);
                    mismatch_count++;
                end else begin
                    run_check_head : begin
                        tps_res_t want;
                        want = segment_results_due.pop_front();
                        compare_field("out_byte",    want.out_byte,    m_out_byte);
                        compare_field("byte_valid",  want.byte_valid,  m_byte_valid);
                        compare_field("segment_end", want.segment_end, m_segment_end);
                        compare_field("text_done",   want.text_done,   m_text_done);
                        compare_field("status",      want.status,      m_status);
                        compare_field("overflow",    want.overflow,    m_overflow);
                        compare_field("last_of_run", want.last_of_run, m_last_of_run);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Requests past the cap are not queued, so each phase sends a fixed count
    task automatic add_request(input logic [7:0] b, input logic has, input logic closes);
        text_req_t r;
        if (queued_count < request_cap) begin
            r.text_byte   = b;
            r.has_byte    = has;
            r.end_of_text = closes;
            text_requests.insert(text_requests.size(), r);
            if (has || closes)
                queued_count++;
        end
    endtask

    function automatic logic [7:0] pick_word_byte();
        if ($urandom_range(9) == 0)
            return 8'h80 + 8'($urandom_range(127));
        return 8'h21 + 8'($urandom_range(8'h5D));
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(1) ? CH_SP : CH_TAB;
    endfunction

    // Blank line in one of its spellings
    task automatic queue_break();
        case ($urandom_range(4))
            0: begin add_request(CH_LF, 1'b1, 1'b0); add_request(CH_LF, 1'b1, 1'b0); end
            1: begin
                add_request(CH_CR, 1'b1, 1'b0); add_request(CH_LF, 1'b1, 1'b0);
                add_request(CH_CR, 1'b1, 1'b0); add_request(CH_LF, 1'b1, 1'b0);
            end
            2: begin add_request(CH_CR, 1'b1, 1'b0); add_request(CH_CR, 1'b1, 1'b0); end
            3: begin
                add_request(CH_CR, 1'b1, 1'b0); add_request(CH_LF, 1'b1, 1'b0);
                add_request(CH_LF, 1'b1, 1'b0);
            end
            default: begin
                add_request(CH_LF, 1'b1, 1'b0); add_request(CH_CR, 1'b1, 1'b0);
                add_request(CH_LF, 1'b1, 1'b0); add_request(CH_LF, 1'b1, 1'b0);
            end
        endcase
    endtask

    task automatic queue_segment(input int max_len);
        int len;
        int i;
        repeat ($urandom_range(2)) add_request(pick_blank(), 1'b1, 1'b0);
        len = $urandom_range(1, max_len);
        for (i = 0; i < len; i++) begin
            case ($urandom_range(11))
                0: add_request(pick_blank(), 1'b1, 1'b0);
                1: add_request(CH_LF, 1'b1, 1'b0);  // line break inside a paragraph
                2: begin
                    if ($urandom_range(1))
                        add_request(CH_DEL, 1'b1, 1'b0);
                    else
                        add_request(8'($urandom_range(31)), 1'b1, 1'b0);
                end
                default: add_request(pick_word_byte(), 1'b1, 1'b0);
            endcase
        end
        // occasionally a trailing run long enough to fill the hold buffer
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(28, 40)) add_request(pick_blank(), 1'b1, 1'b0);
    endtask

    task automatic queue_text();
        int n_segs;
        int max_len;
        int s;
        n_segs  = $urandom_range(1, 4);
        max_len = ($urandom_range(3) == 0) ? 40 : 16;
        for (s = 0; s < n_segs; s++) begin
            queue_segment(max_len);
            if (s != n_segs - 1)
                queue_break();
        end
        case ($urandom_range(3))
            0: add_request(8'($urandom_range(255)), 1'b0, 1'b1);
            1: add_request(pick_word_byte(), 1'b1, 1'b1);
            2: begin queue_break(); add_request(8'($urandom_range(255)), 1'b0, 1'b1); end
            default: begin
                repeat ($urandom_range(1, 3)) add_request(pick_blank(), 1'b1, 1'b0);
                add_request(pick_blank(), 1'b1, 1'b1);
            end
        endcase
    endtask

    task automatic queue_noise(input int n);
        repeat (n) add_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                               $urandom_range(15) == 0);
    endtask

    // Sender stops; wait for every result plus a margin for requests that
    // only touched the hold RAM
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (text_requests.size() != 0 || s_valid || segment_results_due.size() != 0);
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_min_length(input logic [4:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_min_segment_length <= v;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_len = v;
    endtask

    task automatic run_phase(input logic [4:0] v, input int unsigned gap,
                             input int unsigned stall, input int unsigned budget,
                             input logic pause_midway);
        int unsigned start;
        logic        paused;
        send_gap_pct   = gap;
        recv_stall_pct = stall;
        write_min_length(v);
        start       = queued_count;
        request_cap = start + budget;
        paused      = 1'b0;
        while (queued_count - start < budget) begin
            if ($urandom_range(5) == 0)
                queue_noise($urandom_range(1, 6));
            else
                queue_text();
            if (pause_midway && !paused && queued_count - start >= budget / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();
    endtask

    initial begin
        cr_pending   = 1'b0;
        lf_run       = NL_NONE;
        text_seen    = 1'b0;
        min_len      = TPS_MIN_LEN_RESET;
        run_has_tail = 1'b0;
        close_segment();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed texts at the reset minimum of ten
        add_request(8'h00, 1'b0, 1'b1);             // empty text, error status
        add_request(8'hFF, 1'b0, 1'b0);             // no byte, no end: nothing
        add_request(8'h00, 1'b1, 1'b1);             // only a dropped byte: ok
        add_request(CH_TAB, 1'b1, 1'b0);            // leading blanks trimmed
        add_request(CH_SP, 1'b1, 1'b0);
        add_request(8'hFF, 1'b1, 1'b0);
        add_request(8'h80, 1'b1, 1'b0);
        add_request("A", 1'b1, 1'b0);
        add_request("B", 1'b1, 1'b0);
        add_request("C", 1'b1, 1'b0);
        add_request("D", 1'b1, 1'b0);
        add_request(CH_DEL, 1'b1, 1'b0);            // DEL dropped
        add_request("E", 1'b1, 1'b0);
        add_request("F", 1'b1, 1'b0);
        add_request("G", 1'b1, 1'b0);
        add_request("H", 1'b1, 1'b0);               // tenth byte: segment goes out
        add_request(CH_SP, 1'b1, 1'b0);
        add_request(CH_CR, 1'b1, 1'b0);             // CR LF is one line break
        add_request(CH_LF, 1'b1, 1'b0);
        add_request(CH_CR, 1'b1, 1'b0);             // blank line closes segment
        add_request("Z", 1'b1, 1'b0);               // short segment, dropped
        add_request(CH_CR, 1'b1, 1'b0);
        add_request(CH_CR, 1'b1, 1'b0);
        add_request("Q", 1'b1, 1'b1);               // byte and end together
        wait_drained();

        run_phase(5'd1,  14, 50, 50, 1'b0);
        run_phase(5'd31, 14, 50, 50, 1'b0);
        run_phase(5'd0,  50, 14, 50, 1'b1);
        run_phase(5'd16, 50, 14, 50, 1'b0);
        run_phase(5'd5,  0,  0,  50, 1'b0);
        run_phase(5'd24, 0,  0,  50, 1'b0);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
